// File: rtl/pps_pkg.sv
`timescale 1ns / 1ps

package pps_pkg;

    // Largest table the scan chain is built for by default.
    localparam int SLOTS_DEF = 16;

    // Item kinds.
    localparam logic [1:0] KIND_LOAD    = 2'd0;
    localparam logic [1:0] KIND_TICK    = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;

    // Configuration register index.
    localparam logic REG_PROCESS_COUNT = 1'b0;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  slot;
        logic [7:0]  proc_id;
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [15:0] prio;
    } t_item;

    typedef struct packed {
        logic        idle;
        logic [3:0]  run_slot;
        logic [7:0]  run_id;
        logic [15:0] tick_time;
        logic        new_segment;
        logic        finished;
        logic [15:0] finish_time;
        logic [15:0] turnaround;
        logic [15:0] waiting;
        logic        all_done;
    } t_result;

    // Scan word handed from cell to cell; the winning index travels beside it.
    typedef struct packed {
        logic        valid;
        logic        found;
        logic        any_other;  // a slot other than the current best has work
        logic        any_left;   // any slot in use has work
        logic [7:0]  id;
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [15:0] left;
        logic [15:0] prio;
    } t_tok;

    // Per-cycle commands broadcast to every cell.
    typedef struct packed {
        logic load;
        logic restart;
        logic dec;
    } t_cell_ctl;

endpackage

// File: rtl/preemptive_priority_scheduler_core.sv
`timescale 1ns / 1ps

// Preemptive priority scheduler with a table of SLOTS process slots.
// Command channel: a word on i_item is taken at a clock edge where start is
// high and busy is low. A load word fills one slot, a tick word runs the
// best eligible process for one time unit, and a restart word sets the time
// to zero and refills every remaining burst of the slots in use.
// Every word produces exactly one result word on o_result, shown for one
// cycle with o_res_valid high. The receiver cannot stall; it must take the
// result in that cycle.
// Each slot lives in one cell of a chain. After a word is taken, a scan word
// walks the chain one cell per cycle, keeping the lowest priority number
// seen among arrived slots with work left (lowest index on a tie). Loads and
// restarts are applied to the table on the accept edge, a tick's decrement on
// the edge that ends the scan, and the result is registered once the scan word
// leaves the last cell; busy stays high until then. The chain length sets how
// long a word occupies the block.
// The APB port holds process_count at address 0; writes take effect at once
// and are meant to be made only while the block is idle.
// Reset clears the time, the chart segment, the remaining work and the
// count; slot contents are undefined until loaded.

module preemptive_priority_scheduler_core #(
    parameter int SLOTS = pps_pkg::SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  pps_pkg::t_item    i_item,
    output logic              o_res_valid,
    output pps_pkg::t_result  o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import pps_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = ((IW > 5) ? IW : 5) + 1;

    logic          r_busy;
    logic          r_inject;
    logic [1:0]    r_kind;
    logic [15:0]   r_now;
    logic [7:0]    r_last_id;
    logic          r_seg_open;
    logic [4:0]    r_count;
    logic          r_res_valid;
    t_result       r_result;
    t_result       n_result;

    logic          accept;
    logic          finish;
    logic          cfg_wr;
    t_cell_ctl     ctl;
    logic [CW-1:0] tgt;
    t_tok          end_tok;
    logic [IW-1:0] end_idx;
    logic          is_tick;
    logic          ran;
    logic [15:0]   left_after;
    logic [15:0]   fin_time;
    logic [15:0]   tat;

    t_tok          w_tok [SLOTS+1];
    logic [IW-1:0] w_idx [SLOTS+1];

    assign accept  = start && !r_busy;
    assign end_tok = w_tok[SLOTS];
    assign end_idx = w_idx[SLOTS];
    assign finish  = end_tok.valid;
    assign is_tick = r_kind == KIND_TICK;

    // Table commands: loads and restarts land on the accept edge, the
    // winner's decrement lands on the edge that ends the scan.
    always_comb begin
        ctl.load    = accept && (i_item.kind == KIND_LOAD);
        ctl.restart = accept && (i_item.kind == KIND_RESTART);
        ctl.dec     = finish && is_tick && end_tok.found;
        tgt         = ctl.dec ? CW'(end_idx) : CW'(i_item.slot);
    end

    // The scan word enters the first cell empty.
    always_comb begin
        w_tok[0]       = '0;
        w_tok[0].valid = r_inject;
        w_idx[0]       = '0;
    end

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        pps_cell #(
            .SLOTS    (SLOTS),
            .CELL_IDX (g),
            .IW       (IW),
            .CW       (CW)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (ctl),
            .i_tgt     (tgt),
            .i_item    (i_item),
            .i_count   (r_count),
            .i_now     (r_now),
            .i_is_tick (is_tick),
            .i_tok     (w_tok[g]),
            .i_idx     (w_idx[g]),
            .o_tok     (w_tok[g+1]),
            .o_idx     (w_idx[g+1])
        );
    end

    // Result assembly once the scan word leaves the last cell.
    assign ran        = is_tick && end_tok.found;
    assign left_after = end_tok.left - 16'd1;
    assign fin_time   = r_now + 16'd1;
    assign tat        = fin_time - end_tok.arrival;

    always_comb begin
        n_result           = '0;
        n_result.tick_time = r_now;
        if (is_tick) begin
            n_result.idle     = !end_tok.found;
            n_result.all_done = !(end_tok.any_other ||
                                  (end_tok.found && (end_tok.left != 16'd1)));
            if (ran) begin
                n_result.run_slot    = 4'(end_idx);
                n_result.run_id      = end_tok.id;
                n_result.new_segment = !r_seg_open || (r_last_id != end_tok.id);
                if (left_after == 16'd0) begin
                    n_result.finished    = 1'b1;
                    n_result.finish_time = fin_time;
                    n_result.turnaround  = tat;
                    n_result.waiting     = tat - end_tok.burst;
                end
            end
        end else begin
            n_result.all_done = !end_tok.any_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_inject    <= 1'b0;
            r_kind      <= KIND_LOAD;
            r_now       <= 16'd0;
            r_last_id   <= 8'd0;
            r_seg_open  <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_inject    <= accept;
            r_res_valid <= finish;
            if (accept) begin
                r_busy <= 1'b1;
                r_kind <= i_item.kind;
                if (i_item.kind == KIND_RESTART) begin
                    r_now      <= 16'd0;
                    r_last_id  <= 8'd0;
                    r_seg_open <= 1'b0;
                end
            end else if (finish) begin
                r_busy <= 1'b0;
                if (is_tick) begin
                    r_now <= fin_time;
                end
                if (ran) begin
                    r_last_id  <= end_tok.id;
                    r_seg_open <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_result <= n_result;
        end
    end

    // Configuration port.
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_PROCESS_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 5'd0;
        end else if (cfg_wr) begin
            r_count <= pwdata[4:0];
        end
    end

    assign prdata = (paddr[2] == REG_PROCESS_COUNT) ? {27'd0, r_count} : 32'd0;
    assign pready = 1'b1;

    assign busy        = r_busy;
    assign o_res_valid = r_res_valid;
    assign o_result    = r_result;

endmodule

// File: rtl/pps_cell.sv
`timescale 1ns / 1ps

module pps_cell #(
    parameter int SLOTS    = pps_pkg::SLOTS_DEF,
    parameter int CELL_IDX = 0,
    parameter int IW       = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    parameter int CW       = ((IW > 5) ? IW : 5) + 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pps_pkg::t_cell_ctl   i_ctl,
    input  logic [CW-1:0]        i_tgt,
    input  pps_pkg::t_item       i_item,
    input  logic [4:0]           i_count,
    input  logic [15:0]          i_now,
    input  logic                 i_is_tick,
    input  pps_pkg::t_tok        i_tok,
    input  logic [IW-1:0]        i_idx,
    output pps_pkg::t_tok        o_tok,
    output logic [IW-1:0]        o_idx
);
    import pps_pkg::*;

    logic [7:0]    r_id;
    logic [15:0]   r_arrival;
    logic [15:0]   r_burst;
    logic [15:0]   r_prio;
    logic [15:0]   r_left;
    t_tok          r_tok;
    logic [IW-1:0] r_idx;
    t_tok          n_tok;
    logic [IW-1:0] n_idx;

    logic used;
    logic has_work;
    logic eligible;
    logic take;
    logic hit;

    assign used     = CW'(CELL_IDX) < CW'(i_count);
    assign hit      = i_tgt == CW'(CELL_IDX);
    assign has_work = used && (r_left != 16'd0);
    assign eligible = has_work && i_is_tick && (r_arrival <= i_now);
    assign take     = eligible && (!i_tok.found || (r_prio < i_tok.prio));

    always_comb begin
        n_tok           = i_tok;
        n_idx           = i_idx;
        n_tok.found     = i_tok.found | take;
        n_tok.any_left  = i_tok.any_left | has_work;
        // A displaced best still has work, so it joins the others.
        n_tok.any_other = i_tok.any_other | (has_work && (!take || i_tok.found));
        if (take) begin
            n_tok.id      = r_id;
            n_tok.arrival = r_arrival;
            n_tok.burst   = r_burst;
            n_tok.left    = r_left;
            n_tok.prio    = r_prio;
            n_idx         = IW'(CELL_IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
        r_idx <= n_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 16'd0;
        end else begin
            priority if (i_ctl.load && hit) begin
                r_left <= i_item.burst;
            end else if (i_ctl.restart && used) begin
                r_left <= r_burst;
            end else if (i_ctl.dec && hit) begin
                r_left <= r_left - 16'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load && hit) begin
            r_id      <= i_item.proc_id;
            r_arrival <= i_item.arrival;
            r_burst   <= i_item.burst;
            r_prio    <= i_item.prio;
        end
    end

    assign o_tok = r_tok;
    assign o_idx = r_idx;

endmodule

// File: tb/preemptive_priority_scheduler_core_tb.sv
`timescale 1ns / 1ps

module preemptive_priority_scheduler_core_tb;

    import pps_pkg::*;

    // Table size of the block under test, which is also the length of its scan chain.
    localparam int SLOTS = SLOTS_DEF;
    localparam int HALF_PERIOD = 4;
    // Kind three is spare: the block answers it like a load but stores nothing.
    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam logic [2:0] ADDR_PROCESS_COUNT = 3'(4 * REG_PROCESS_COUNT);
    localparam int RANDOM_WORDS = 1800;
    // Ticks sent with no gap after the back-to-back loads.
    localparam int RUN_TICKS = 40;
    localparam int REPORT_LIMIT = 10;
    localparam int TICK_CAP = 150;

    // One row of the directed table: either a register write or a command word,
    // with an expected result typed in where it is obvious.
    typedef struct packed {
        logic       is_cfg;
        logic [4:0] cfg_val;
        t_item      word;
        logic       typed;
        t_result    res;
    } t_step_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_item       i_item = '0;
    logic        o_res_valid;
    t_result     o_result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Shadow copy of the process table, the clock and the chart segment.
    logic [7:0]  id_tab      [SLOTS] = '{default: '0};
    logic [15:0] arrival_tab [SLOTS] = '{default: '0};
    logic [15:0] burst_tab   [SLOTS] = '{default: '0};
    logic [15:0] prio_tab    [SLOTS] = '{default: '0};
    logic [15:0] left_tab    [SLOTS] = '{default: '0};
    logic [15:0] now_ticks = '0;
    logic [7:0]  segment_id = '0;
    logic        segment_live = 1'b0;
    logic [4:0]  proc_count = '0;

    // Results owed by the block, oldest first.
    t_result     pending_results[$];
    t_step_row   directed_rows[$];
    int          failures = 0;
    int          results_seen = 0;
    int          burst_left = 0;
    bit          pacing = 1'b0;

    preemptive_priority_scheduler_core #(
        .SLOTS(SLOTS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_res_valid(o_res_valid),
        .o_result   (o_result),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // A count above the table size acts as the full table.
    function automatic int slots_in_use();
        return (proc_count > SLOTS) ? SLOTS : int'(proc_count);
    endfunction

    function automatic bit work_remains();
        for (int i = 0; i < slots_in_use(); i++) begin
            if (left_tab[i] != 16'd0) return 1'b1;
        end
        return 1'b0;
    endfunction

    // Applies one accepted command word to the shadow table and returns the
    // result word the block owes for it.
    function automatic t_result schedule_word(input t_item w);
        t_result     r;
        int          n;
        int          best;
        bit          found;
        logic [15:0] t0;
        logic [15:0] done_at;
        r = '0;
        n = slots_in_use();
        best = 0;
        found = 1'b0;
        t0 = now_ticks;
        case (w.kind)
            KIND_TICK: begin
                // Lowest priority number among arrived slots with work left;
                // the strict compare keeps the lowest index on a tie.
                for (int i = 0; i < n; i++) begin
                    if (arrival_tab[i] <= t0 && left_tab[i] != 16'd0 &&
                        (!found || prio_tab[i] < prio_tab[best])) begin
                        best = i;
                        found = 1'b1;
                    end
                end
                r.tick_time = t0;
                if (!found) begin
                    // An idle tick leaves the chart segment alone.
                    r.idle = 1'b1;
                end else begin
                    r.run_slot = 4'(best);
                    r.run_id = id_tab[best];
                    r.new_segment = !segment_live || segment_id != id_tab[best];
                    segment_id = id_tab[best];
                    segment_live = 1'b1;
                    left_tab[best] = left_tab[best] - 16'd1;
                    if (left_tab[best] == 16'd0) begin
                        done_at = t0 + 16'd1;
                        r.finished = 1'b1;
                        r.finish_time = done_at;
                        r.turnaround = done_at - arrival_tab[best];
                        r.waiting = r.turnaround - burst_tab[best];
                    end
                end
                now_ticks = t0 + 16'd1;
            end
            KIND_RESTART: begin
                for (int i = 0; i < n; i++) begin
                    left_tab[i] = burst_tab[i];
                end
                now_ticks = '0;
                segment_id = '0;
                segment_live = 1'b0;
                r.tick_time = '0;
            end
            default: begin
                if (w.kind == KIND_LOAD && int'(w.slot) < SLOTS) begin
                    id_tab[w.slot] = w.proc_id;
                    arrival_tab[w.slot] = w.arrival;
                    burst_tab[w.slot] = w.burst;
                    prio_tab[w.slot] = w.prio;
                    left_tab[w.slot] = w.burst;
                end
                r.tick_time = now_ticks;
            end
        endcase
        r.all_done = !work_remains();
        return r;
    endfunction

    function automatic t_item make_word(input logic [1:0] k, input logic [3:0] s,
                                        input logic [7:0] id, input logic [15:0] arr,
                                        input logic [15:0] bur, input logic [15:0] pri);
        t_item w;
        w.kind = k;
        w.slot = s;
        w.proc_id = id;
        w.arrival = arr;
        w.burst = bur;
        w.prio = pri;
        return w;
    endfunction

    // Tick and restart words carry random junk in the fields they do not use.
    function automatic t_item junk_word(input logic [1:0] k);
        return make_word(k, 4'($urandom), 8'($urandom), 16'($urandom),
                         16'($urandom), 16'($urandom));
    endfunction

    // Most loads use small times, bursts and priorities so that processes
    // arrive, compete, tie and finish; a wild load spans the full range.
    function automatic t_item random_load(input int s, input bit wild);
        if (wild) begin
            return make_word(KIND_LOAD, 4'(s), 8'($urandom), 16'($urandom),
                             16'($urandom), 16'($urandom));
        end
        return make_word(KIND_LOAD, 4'(s), 8'($urandom), 16'($urandom_range(0, 12)),
                         16'($urandom_range(0, 6)), 16'($urandom_range(0, 3)));
    endfunction

    function automatic t_result quiet_result(input logic idle_flag,
                                             input logic [15:0] at_time,
                                             input logic done_flag);
        t_result r;
        r = '0;
        r.idle = idle_flag;
        r.tick_time = at_time;
        r.all_done = done_flag;
        return r;
    endfunction

    function automatic t_step_row word_row(input t_item w);
        t_step_row r;
        r = '0;
        r.word = w;
        return r;
    endfunction

    function automatic t_step_row cfg_row(input logic [4:0] value);
        t_step_row r;
        r = '0;
        r.is_cfg = 1'b1;
        r.cfg_val = value;
        return r;
    endfunction

    function automatic t_step_row with_expect(input t_step_row r, input t_result e);
        r.typed = 1'b1;
        r.res = e;
        return r;
    endfunction

    task automatic note_failure(input string msg);
        failures++;
        if (failures <= REPORT_LIMIT) $display("%s", msg);
    endtask

    task automatic compare_result(input t_result got, input t_result want);
        string bad;
        bad = "";
        if (got.idle !== want.idle) bad = {bad, " idle"};
        if (got.run_slot !== want.run_slot) bad = {bad, " run_slot"};
        if (got.run_id !== want.run_id) bad = {bad, " run_id"};
        if (got.tick_time !== want.tick_time) bad = {bad, " tick_time"};
        if (got.new_segment !== want.new_segment) bad = {bad, " new_segment"};
        if (got.finished !== want.finished) bad = {bad, " finished"};
        if (got.finish_time !== want.finish_time) bad = {bad, " finish_time"};
        if (got.turnaround !== want.turnaround) bad = {bad, " turnaround"};
        if (got.waiting !== want.waiting) bad = {bad, " waiting"};
        if (got.all_done !== want.all_done) bad = {bad, " all_done"};
        if (bad != "") begin
            note_failure($sformatf("result word %0d wrong in%s: expected %p, got %p",
                                   results_seen, bad, want, got));
        end
    endtask

    // Result monitor. The receiver cannot stall, so every strobe is taken and
    // matched against the oldest owed result.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_res_valid) begin
            if (pending_results.size() == 0) begin
                note_failure($sformatf("result word %0d arrived with none owed: %p",
                                       results_seen, o_result));
            end else begin
                want = pending_results.pop_front();
                compare_result(o_result, want);
            end
            results_seen++;
        end
    end

    // Presents one command word and returns at the edge that accepts it.
    // Start is left high so a following word can go out back to back; the
    // caller lowers it through hold_off or drain in the same time step.
    task automatic send_word(input t_item w, input bit has_typed, input t_result typed_res);
        t_result pred;
        if (!start) start <= 1'b1;
        i_item <= w;
        do @(posedge i_clk); while (busy);
        pred = schedule_word(w);
        pending_results.push_back(has_typed ? typed_res : pred);
    endtask

    task automatic hold_off(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // The sender works in bursts of random length separated by random gaps,
    // some of them longer than a whole scan so they land on every phase.
    task automatic send_paced(input t_item w);
        if (pacing) begin
            if (burst_left == 0) begin
                hold_off(($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 18));
                burst_left = $urandom_range(1, 12);
            end
            burst_left--;
        end
        send_word(w, 1'b0, '0);
    endtask

    // Waits until every owed result has come and the block has gone quiet.
    task automatic drain();
        start <= 1'b0;
        while (pending_results.size() != 0 || busy) @(posedge i_clk);
    endtask

    // Writes process_count while the block is idle, then reads it back.
    task automatic write_count(input logic [4:0] value);
        drain();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_PROCESS_COUNT;
        pwdata <= {27'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        proc_count = value;
        // Straight into the read setup; psel stays high.
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {27'd0, value}) begin
            note_failure($sformatf("process_count read back %0h, expected %0h",
                                   prdata, value));
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        int steps;
        int pick;
        int random_words;
        int scenario;
        logic [4:0] count_val;

        // Directed table. While the count is zero no slot is in use, so every
        // answer is a quiet one with all_done set. Loads cover the extremes of
        // every field, a zero burst and the latest possible arrival.
        directed_rows.push_back(with_expect(word_row(make_word(KIND_TICK, 4'd0, 8'd0,
            16'd0, 16'd0, 16'd0)), quiet_result(1'b1, 16'd0, 1'b1)));
        directed_rows.push_back(with_expect(word_row(make_word(KIND_RESTART, 4'd0, 8'd0,
            16'd0, 16'd0, 16'd0)), quiet_result(1'b0, 16'd0, 1'b1)));
        directed_rows.push_back(with_expect(word_row(make_word(KIND_LOAD, 4'd0, 8'hFF,
            16'd0, 16'd3, 16'hFFFF)), quiet_result(1'b0, 16'd0, 1'b1)));
        directed_rows.push_back(with_expect(word_row(make_word(KIND_LOAD, 4'd1, 8'h00,
            16'hFFFF, 16'd0, 16'd0)), quiet_result(1'b0, 16'd0, 1'b1)));
        directed_rows.push_back(with_expect(word_row(make_word(KIND_LOAD, 4'd2, 8'h5A,
            16'd1, 16'd2, 16'd0)), quiet_result(1'b0, 16'd0, 1'b1)));
        directed_rows.push_back(with_expect(word_row(make_word(KIND_LOAD, 4'd15, 8'hA5,
            16'd0, 16'hFFFF, 16'h8000)), quiet_result(1'b0, 16'd0, 1'b1)));
        // The spare kind with every bit set must change nothing.
        directed_rows.push_back(with_expect(word_row(make_word(KIND_SPARE, 4'hF, 8'hFF,
            16'hFFFF, 16'hFFFF, 16'hFFFF)), quiet_result(1'b0, 16'd0, 1'b1)));
        // Three slots in use: slot 2 arrives late and preempts slot 0, the
        // zero-burst slot 1 never runs, and the last tick finds nothing to do.
        directed_rows.push_back(cfg_row(5'd3));
        directed_rows.push_back(word_row(junk_word(KIND_RESTART)));
        repeat (6) directed_rows.push_back(word_row(junk_word(KIND_TICK)));
        // Reloading a finished slot gives it fresh work mid-schedule.
        directed_rows.push_back(word_row(make_word(KIND_LOAD, 4'd2, 8'h5A,
            16'd0, 16'd1, 16'hFFFF)));
        directed_rows.push_back(word_row(junk_word(KIND_TICK)));
        directed_rows.push_back(word_row(junk_word(KIND_RESTART)));
        directed_rows.push_back(word_row(junk_word(KIND_TICK)));
        directed_rows.push_back(cfg_row(5'd0));
        directed_rows.push_back(word_row(junk_word(KIND_TICK)));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_cfg) begin
                write_count(directed_rows[i].cfg_val);
            end else begin
                send_word(directed_rows[i].word, directed_rows[i].typed,
                          directed_rows[i].res);
            end
        end

        // Back to back: slot 0 runs a long burst, slot 2 arrives at tick 5 and
        // slot 1 at tick 20, and each of them preempts slot 0 and finishes at
        // once. Words go out with no gap here.
        write_count(5'd3);
        send_word(make_word(KIND_LOAD, 4'd0, 8'h11, 16'd0, 16'hFFFF, 16'd3), 1'b0, '0);
        send_word(make_word(KIND_LOAD, 4'd1, 8'h22, 16'd20, 16'd1, 16'd0), 1'b0, '0);
        send_word(make_word(KIND_LOAD, 4'd2, 8'h33, 16'd5, 16'd1, 16'd1), 1'b0, '0);
        send_word(junk_word(KIND_RESTART), 1'b0, '0);
        repeat (RUN_TICKS) send_word(junk_word(KIND_TICK), 1'b0, '0);

        // Random part. Every slot is loaded first so that any count is safe.
        pacing = 1'b1;
        random_words = 0;
        for (int s = 0; s < SLOTS; s++) begin
            send_paced(random_load(s, 1'b1));
            random_words++;
        end
        scenario = 0;
        while (random_words < RANDOM_WORDS) begin
            // Each scenario: pick a count, reload some slots, restart, then
            // tick until the work runs out, with stray words mixed in.
            pick = $urandom_range(0, 9);
            if (scenario == 0 || pick == 0) count_val = 5'd31;
            else if (pick == 1) count_val = 5'($urandom_range(17, 30));
            else if (pick == 2) count_val = 5'(SLOTS);
            else if (pick == 3) count_val = 5'd0;
            else count_val = 5'($urandom_range(1, 8));
            write_count(count_val);
            scenario++;
            pacing = ($urandom_range(0, 3) != 0);
            for (int s = 0; s < slots_in_use(); s++) begin
                if ($urandom_range(0, 2) != 0) begin
                    send_paced(random_load(s, $urandom_range(0, 15) == 0));
                    random_words++;
                end
            end
            send_paced(junk_word(KIND_RESTART));
            random_words++;
            steps = 0;
            while (work_remains() && steps < TICK_CAP) begin
                pick = $urandom_range(0, 47);
                if (pick == 0) begin
                    send_paced(junk_word(KIND_RESTART));
                    random_words++;
                end else if (pick < 3) begin
                    // The spare kind is ignored, so it is not counted.
                    send_paced(junk_word(KIND_SPARE));
                end else if (pick < 6) begin
                    send_paced(random_load($urandom_range(0, SLOTS - 1),
                                           $urandom_range(0, 7) == 0));
                    random_words++;
                end else begin
                    send_paced(junk_word(KIND_TICK));
                    random_words++;
                end
                steps++;
            end
            // Up to two more ticks, which are idle if every slot has finished.
            repeat ($urandom_range(0, 2)) begin
                send_paced(junk_word(KIND_TICK));
                random_words++;
            end
        end

        drain();
        repeat (SLOTS + 4) @(posedge i_clk);
        if (failures == 0) begin
            $display("preemptive_priority_scheduler_core verification clean");
        end else begin
            $display("preemptive_priority_scheduler_core verification failed");
        end
        $finish;
    end

    // Watchdog, several times the slowest correct run: about two thousand
    // words, every one behind the longest gap.
    initial begin
        #10_000_000;
        $display("preemptive_priority_scheduler_core verification failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/pps_pkg.sv
rtl/pps_cell.sv
rtl/preemptive_priority_scheduler_core.sv
tb/preemptive_priority_scheduler_core_tb.sv
